>>> rtl/core/battery_voltage_window_monitor_macros.svh
// Assertion macros shared by the monitor RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef BATTERY_VOLTAGE_WINDOW_MONITOR_MACROS_SVH
`define BATTERY_VOLTAGE_WINDOW_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define BVWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define BVWM_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`else

`define BVWM_ASSERT(lbl, prop, msg)
`define BVWM_ASSERT_NEXT(lbl, cause, effect, msg)

`endif

`endif

>>> rtl/core/bvwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvwm_pkg;

    // Field widths
    localparam int CODE_W     = 16;
    localparam int CFG_W      = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int MV_W       = 14;
    localparam int LVL_W      = 3;
    localparam int RES_W      = 2;
    localparam int CNT_W      = 32;

    // Millivolt span of a full-scale code: 5 V reference times a divider of 3.
    localparam int MV_SPAN = 15000;

    // Result codes
    localparam logic [RES_W-1:0] RES_OK        = 2'd0;
    localparam logic [RES_W-1:0] RES_ADC_FAULT = 2'd1;
    localparam logic [RES_W-1:0] RES_RANGE     = 2'd2;

    // Battery levels
    localparam logic [LVL_W-1:0] LVL_UNKNOWN  = 3'd0;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd1;
    localparam logic [LVL_W-1:0] LVL_LOW      = 3'd2;
    localparam logic [LVL_W-1:0] LVL_NORMAL   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_HIGH     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PLAUS_MIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLAUS_MAX = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRIT_BELOW = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_BELOW = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORM_UPTO = 3'd4;

    // Configuration reset values in millivolts
    localparam logic [CFG_W-1:0] RST_PLAUS_MIN  = 15'd8000;
    localparam logic [CFG_W-1:0] RST_PLAUS_MAX  = 15'd18000;
    localparam logic [CFG_W-1:0] RST_CRIT_BELOW = 15'd10500;
    localparam logic [CFG_W-1:0] RST_LOW_BELOW  = 15'd11500;
    localparam logic [CFG_W-1:0] RST_NORM_UPTO  = 15'd14000;

    // Threshold registers as seen by the evaluation stage
    typedef struct packed {
        logic [CFG_W-1:0] plausible_min_mv;
        logic [CFG_W-1:0] plausible_max_mv;
        logic [CFG_W-1:0] critical_below_mv;
        logic [CFG_W-1:0] low_below_mv;
        logic [CFG_W-1:0] normal_upto_mv;
    } cfg_t;

    // Converted sample passed from the conversion stage
    typedef struct packed {
        logic            fault;
        logic [MV_W-1:0] mv;
    } mid_t;

    // One result word
    typedef struct packed {
        logic [CNT_W-1:0] range_error_count;
        logic [CNT_W-1:0] fault_count;
        logic [CNT_W-1:0] level_change_count;
        logic [MV_W-1:0]  highest_mv;
        logic [MV_W-1:0]  lowest_mv;
        logic [CNT_W-1:0] valid_count;
        logic [LVL_W-1:0] battery_level;
        logic [MV_W-1:0]  voltage_mv;
        logic [RES_W-1:0] result_code;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bvwm_conv.sv
`timescale 1ns / 1ps
`default_nettype none

// Input register, fault check and code-to-millivolt scaling.
// The scaling floor(code * 15000 / (2^ADC_BITS - 1)) is done as a multiply by
// a rounded-up reciprocal with 2*ADC_BITS fraction bits, which is exact for
// every code up to full scale.
module bvwm_conv
    import bvwm_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CODE_W-1:0] in_code,
    output logic                   mid_valid,
    input  wire logic              mid_ready,
    output mid_t                   mid
);

    localparam logic [63:0] FULL_64 = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] RECIP_64 =
        ((64'(MV_SPAN) << (2 * ADC_BITS)) + FULL_64 - 64'd1) / FULL_64;
    localparam int RECIP_W = ADC_BITS + 15;
    localparam int PROD_W  = CODE_W + RECIP_W;
    localparam int FRAC_W  = 2 * ADC_BITS;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_64[RECIP_W-1:0];
    localparam logic [CODE_W-1:0]  FULL_CODE = FULL_64[CODE_W-1:0];

    logic              code_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              mid_valid_reg;
    mid_t              mid_reg;
    mid_t              mid_next;
    logic              mid_take;
    logic [PROD_W-1:0] product;

    // Second stage can load when empty or when its word leaves.
    assign mid_take = !mid_valid_reg || mid_ready;
    assign in_ready = !code_valid_reg || mid_take;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            code_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            code_reg <= in_code;
        end
    end

    // Reciprocal multiply and fault detection
    always_comb
    begin
        product        = PROD_W'(code_reg) * PROD_W'(RECIP);
        mid_next.fault = code_reg > FULL_CODE;
        mid_next.mv    = product[FRAC_W +: MV_W];
    end

    // Converted sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_take)
        begin
            mid_valid_reg <= code_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_take && code_valid_reg)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

`default_nettype wire

>>> rtl/core/bvwm_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Window check, level classification, running statistics and result register.
module bvwm_eval
    import bvwm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic mid_valid,
    output logic      mid_ready,
    input  wire mid_t mid,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_word
);

    logic             out_valid_reg;
    result_t          out_reg;
    result_t          out_next;
    logic             take;

    logic [CNT_W-1:0] valid_total_reg;
    logic [CNT_W-1:0] valid_total_next;
    logic [MV_W-1:0]  min_seen_reg;
    logic [MV_W-1:0]  min_seen_next;
    logic [MV_W-1:0]  max_seen_reg;
    logic [MV_W-1:0]  max_seen_next;
    logic [LVL_W-1:0] last_level_reg;
    logic [LVL_W-1:0] last_level_next;
    logic [CNT_W-1:0] changes_total_reg;
    logic [CNT_W-1:0] changes_total_next;
    logic [CNT_W-1:0] faults_total_reg;
    logic [CNT_W-1:0] faults_total_next;
    logic [CNT_W-1:0] range_total_reg;
    logic [CNT_W-1:0] range_total_next;

    logic [CFG_W-1:0] mv_wide;
    logic             out_of_window;
    logic             first;
    logic [LVL_W-1:0] level;
    logic [RES_W-1:0] result;

    assign mid_ready = !out_valid_reg || out_ready;
    assign take      = mid_valid && mid_ready;

    // Classification in the order critical, low, normal, high
    always_comb
    begin
        mv_wide       = CFG_W'(mid.mv);
        out_of_window = (mv_wide < cfg.plausible_min_mv) || (mv_wide > cfg.plausible_max_mv);
        first         = valid_total_reg == '0;
        priority if (mv_wide < cfg.critical_below_mv)
        begin
            level = LVL_CRITICAL;
        end
        else if (mv_wide < cfg.low_below_mv)
        begin
            level = LVL_LOW;
        end
        else if (mv_wide <= cfg.normal_upto_mv)
        begin
            level = LVL_NORMAL;
        end
        else
        begin
            level = LVL_HIGH;
        end
    end

    // Statistics update for the word entering the result register
    always_comb
    begin
        valid_total_next   = valid_total_reg;
        min_seen_next      = min_seen_reg;
        max_seen_next      = max_seen_reg;
        last_level_next    = last_level_reg;
        changes_total_next = changes_total_reg;
        faults_total_next  = faults_total_reg;
        range_total_next   = range_total_reg;
        result             = RES_OK;

        priority if (mid.fault)
        begin
            result            = RES_ADC_FAULT;
            faults_total_next = faults_total_reg + 1'b1;
        end
        else if (out_of_window)
        begin
            result           = RES_RANGE;
            range_total_next = range_total_reg + 1'b1;
        end
        else
        begin
            valid_total_next = valid_total_reg + 1'b1;
            if (first || (mid.mv < min_seen_reg))
            begin
                min_seen_next = mid.mv;
            end
            if (first || (mid.mv > max_seen_reg))
            begin
                max_seen_next = mid.mv;
            end
            if (level != last_level_reg)
            begin
                changes_total_next = changes_total_reg + 1'b1;
            end
            last_level_next = level;
        end

        out_next.result_code        = result;
        out_next.voltage_mv         = (result == RES_OK) ? mid.mv : '0;
        out_next.battery_level      = (result == RES_OK) ? level : LVL_UNKNOWN;
        out_next.valid_count        = valid_total_next;
        out_next.lowest_mv          = min_seen_next;
        out_next.highest_mv         = max_seen_next;
        out_next.level_change_count = changes_total_next;
        out_next.fault_count        = faults_total_next;
        out_next.range_error_count  = range_total_next;
    end

    // Running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_total_reg   <= '0;
            min_seen_reg      <= '0;
            max_seen_reg      <= '0;
            last_level_reg    <= LVL_UNKNOWN;
            changes_total_reg <= '0;
            faults_total_reg  <= '0;
            range_total_reg   <= '0;
        end
        else if (take)
        begin
            valid_total_reg   <= valid_total_next;
            min_seen_reg      <= min_seen_next;
            max_seen_reg      <= max_seen_next;
            last_level_reg    <= last_level_next;
            changes_total_reg <= changes_total_next;
            faults_total_reg  <= faults_total_next;
            range_total_reg   <= range_total_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/battery_voltage_window_monitor.sv
// Pipeline: a word accepted on the slave side passes the input register, the scaling
// register and the result register in that order before it reaches the master side.
// Throughput: one word per cycle unless m_axis_tready stalls it; the single reciprocal
// multiplier sits alone between the input register and the scaling register.
// Reset: rst_n is asynchronous and active low; it empties the pipeline, zeroes
// all counters, minimum, maximum and last level, and loads the default thresholds.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_voltage_window_monitor_macros.svh"

module battery_voltage_window_monitor
    import bvwm_pkg::*;
#(
    parameter int ADC_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input word: adc_code [15:0]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,
    // Result word, from bit 0 up: result_code [1:0], voltage_mv [15:2],
    // battery_level [18:16], valid_count [50:19], lowest_mv [64:51],
    // highest_mv [78:65], level_change_count [110:79], fault_count [142:111],
    // range_error_count [174:143], zero pad [175]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [175:0]               m_axis_tdata,
    // Threshold register writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    cfg_t    cfg_reg;
    logic    mid_valid;
    logic    mid_ready;
    mid_t    mid;
    result_t out_word;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plausible_min_mv  <= RST_PLAUS_MIN;
            cfg_reg.plausible_max_mv  <= RST_PLAUS_MAX;
            cfg_reg.critical_below_mv <= RST_CRIT_BELOW;
            cfg_reg.low_below_mv      <= RST_LOW_BELOW;
            cfg_reg.normal_upto_mv    <= RST_NORM_UPTO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PLAUS_MIN:  cfg_reg.plausible_min_mv  <= cfg_wdata;
                CFG_PLAUS_MAX:  cfg_reg.plausible_max_mv  <= cfg_wdata;
                CFG_CRIT_BELOW: cfg_reg.critical_below_mv <= cfg_wdata;
                CFG_LOW_BELOW:  cfg_reg.low_below_mv      <= cfg_wdata;
                CFG_NORM_UPTO:  cfg_reg.normal_upto_mv    <= cfg_wdata;
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Conversion stages
    bvwm_conv #(
        .ADC_BITS (ADC_BITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_code   (s_axis_tdata),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    // Evaluation and result register
    bvwm_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // Pack the result word, pad bit on top.
    assign m_axis_tdata = {1'b0, out_word};

    // A good reading always lies between the tracked extremes.
    `BVWM_ASSERT(a_ok_within_extremes,
        !m_axis_tvalid || (out_word.result_code != RES_OK) ||
        ((out_word.lowest_mv <= out_word.voltage_mv) &&
         (out_word.voltage_mv <= out_word.highest_mv)),
        "valid reading outside lowest/highest")

    // A rejected reading carries no voltage and an unknown level.
    `BVWM_ASSERT(a_error_blank,
        !m_axis_tvalid || (out_word.result_code == RES_OK) ||
        ((out_word.voltage_mv == '0) && (out_word.battery_level == LVL_UNKNOWN)),
        "error result with voltage or level")

    // An empty result register means the pipeline can take input.
    `BVWM_ASSERT(a_no_stall_when_empty,
        m_axis_tvalid || s_axis_tready,
        "input stalled with empty result register")

    // A stalled scaled sample is held.
    `BVWM_ASSERT_NEXT(a_mid_hold,
        mid_valid && !mid_ready,
        mid_valid && $stable(mid),
        "scaled sample lost while stalled")

endmodule

`default_nettype wire
